@@ rtl/core/oal_pkg.sv @@
// Ordered array list: shared types, codes and sizing constants.
// No dependencies; compiled first.
package oal_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int LEN_W    = 7;
   localparam int CNT_W    = 7;
   localparam int VAL_W    = 32;
   localparam int CMP_W    = (FILL_W > POS_W) ? FILL_W : POS_W;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_COUNT  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic start;
      logic walk;
      logic put;
      logic commit;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      status_type status;
      logic       has_walk;
      logic       at_end;
      logic       needs_put;
   } dp_sts_type;

endpackage

@@ rtl/core/oal_if.sv @@
// Ordered array list: request and response channel interfaces.
// Depends on oal_pkg.
interface oal_req_if;
   import oal_pkg::*;
   logic                    valid;
   logic                    ready;
   kind_type                kind;
   logic signed [VAL_W-1:0] value;
   logic [POS_W-1:0]        position;

   modport source (output valid, kind, value, position, input ready);
   modport sink   (input valid, kind, value, position, output ready);
endinterface

interface oal_rsp_if;
   import oal_pkg::*;
   logic             valid;
   logic             ready;
   status_type       status;
   logic [CNT_W-1:0] match_count;
   logic [LEN_W-1:0] length;

   modport source (output valid, status, match_count, length, input ready);
   modport sink   (input valid, status, match_count, length, output ready);
endinterface

@@ rtl/core/oal_datapath.sv @@
// Ordered array list datapath: entry memory, fill, walk cursor, match counter
// and result register. Depends on oal_pkg; driven by oal_control.
module oal_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  oal_pkg::dp_cmd_type             cmd,
   output oal_pkg::dp_sts_type             sts,
   input  oal_pkg::kind_type               in_kind,
   input  logic signed [oal_pkg::VAL_W-1:0] in_value,
   input  logic [oal_pkg::POS_W-1:0]       in_position,
   output oal_pkg::status_type             out_status,
   output logic [oal_pkg::CNT_W-1:0]       out_match_count,
   output logic [oal_pkg::LEN_W-1:0]       out_length
);
   import oal_pkg::*;

   logic [VAL_W-1:0]  mem [CAPACITY];

   kind_type          kind_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [ADDR_W-1:0] cursor_ff;
   logic [ADDR_W-1:0] end_ff;
   logic [ADDR_W-1:0] prev_ff;
   logic              pend_ff;
   logic [VAL_W-1:0]  rdata_ff;
   logic [FILL_W-1:0] count_ff;
   status_type        res_status_ff;
   logic [CNT_W-1:0]  res_match_ff;
   logic [LEN_W-1:0]  res_len_ff;

   logic [CMP_W-1:0]  fill_x;
   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  pos_eff_x;
   logic              is_put;
   logic              down;
   status_type        status;
   logic              has_walk;
   logic [ADDR_W-1:0] start_addr;
   logic [ADDR_W-1:0] end_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;

   always_comb begin
      fill_x    = CMP_W'(fill_ff);
      pos_x     = CMP_W'(pos_ff);
      is_put    = (kind_ff == KIND_INSERT) || (kind_ff == KIND_APPEND);
      down      = is_put;
      pos_eff_x = (kind_ff == KIND_APPEND) ? fill_x : pos_x;
      status    = ST_DONE;
      has_walk  = 1'b0;
      start_addr = '0;
      end_addr   = '0;
      case (kind_ff)
         KIND_INSERT, KIND_APPEND: begin
            if (fill_x >= CMP_W'(CAPACITY)) begin
               status = ST_FULL;
            end else if (pos_eff_x > fill_x) begin
               status = ST_RANGE;
            end
            has_walk   = fill_x > pos_eff_x;
            start_addr = ADDR_W'(fill_x - CMP_W'(1));
            end_addr   = ADDR_W'(pos_eff_x);
         end
         KIND_REMOVE: begin
            if (pos_x >= fill_x) begin
               status = ST_RANGE;
            end
            has_walk   = (fill_x != '0) && (pos_x < fill_x - CMP_W'(1));
            start_addr = ADDR_W'(pos_x + CMP_W'(1));
            end_addr   = ADDR_W'(fill_x - CMP_W'(1));
         end
         default: begin
            has_walk   = fill_x != '0;
            start_addr = '0;
            end_addr   = ADDR_W'(fill_x - CMP_W'(1));
         end
      endcase
   end

   assign sts.status    = status;
   assign sts.has_walk  = has_walk;
   assign sts.at_end    = cursor_ff == end_ff;
   assign sts.needs_put = is_put;

   // write-back of the entry read last cycle, or the new value itself
   always_comb begin
      wr_en   = cmd.put || (pend_ff && (kind_ff != KIND_COUNT));
      wr_addr = cmd.put ? ADDR_W'(pos_eff_x)
              : (down ? prev_ff + ADDR_W'(1) : prev_ff - ADDR_W'(1));
      wr_data = cmd.put ? value_ff : rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.walk) begin
         rdata_ff <= mem[cursor_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= in_kind;
         value_ff <= in_value;
         pos_ff   <= in_position;
      end
      if (cmd.start) begin
         cursor_ff <= start_addr;
         end_ff    <= end_addr;
      end else if (cmd.walk) begin
         cursor_ff <= down ? cursor_ff - ADDR_W'(1) : cursor_ff + ADDR_W'(1);
      end
      if (cmd.walk) begin
         prev_ff <= cursor_ff;
      end
      if (cmd.start) begin
         count_ff <= '0;
      end else if (pend_ff && (kind_ff == KIND_COUNT) && (rdata_ff == value_ff)) begin
         count_ff <= count_ff + FILL_W'(1);
      end
      if (cmd.commit) begin
         res_status_ff <= status;
         res_match_ff  <= (kind_ff == KIND_COUNT) ? CNT_W'(count_ff) : '0;
         if (status == ST_DONE && is_put) begin
            res_len_ff <= LEN_W'(fill_ff + FILL_W'(1));
         end else if (status == ST_DONE && kind_ff == KIND_REMOVE) begin
            res_len_ff <= LEN_W'(fill_ff - FILL_W'(1));
         end else begin
            res_len_ff <= LEN_W'(fill_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.walk;
         if (cmd.commit && status == ST_DONE) begin
            if (is_put) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end else if (kind_ff == KIND_REMOVE) begin
               fill_ff <= fill_ff - FILL_W'(1);
            end
         end
      end
   end

   assign out_status      = res_status_ff;
   assign out_match_count = res_match_ff;
   assign out_length      = res_len_ff;

endmodule

@@ rtl/core/oal_control.sv @@
// Ordered array list controller: sequences accept, check, walk, put and
// result hand-off. Depends on oal_pkg; commands oal_datapath.
module oal_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output oal_pkg::dp_cmd_type cmd,
   input  oal_pkg::dp_sts_type sts
);
   import oal_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_DRAIN,
      S_PUT,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == S_IDLE) && req_valid;
      cmd.start  = state_ff == S_CHECK;
      cmd.walk   = state_ff == S_WALK;
      cmd.put    = state_ff == S_PUT;
      cmd.commit = (state_ff == S_FINISH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (sts.status != ST_DONE) begin
                  state_ff <= S_FINISH;
               end else if (sts.has_walk) begin
                  state_ff <= S_WALK;
               end else if (sts.needs_put) begin
                  state_ff <= S_PUT;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_WALK: begin
               if (sts.at_end) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= sts.needs_put ? S_PUT : S_FINISH;
            end
            S_PUT: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/ordered_array_list.sv @@
// Ordered array list top level: joins controller and datapath to the
// request and response channels. Depends on oal_pkg, oal_if, oal_control, oal_datapath.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in a single
// memory (one write and one registered read per cycle) and answers one item
// at a time: insert at a position, append, remove at a position, or count
// the entries equal to a value. Each item returns status (done, list full,
// position out of range), match count (count items only, else 0) and the
// length after the item. Full is checked before position. Items that are
// not rejected walk any entries they shift or count through the memory,
// one entry a cycle. A finished result sits in an output register, so the
// next item is accepted while it waits; the block only holds at the end
// of that next item if the first result is still untaken. Reset clears
// the length, not the memory; the memory needs no clearing pass, as only
// entries below the length are ever read.
module ordered_array_list (
   input  logic      clock,
   input  logic      reset,
   oal_req_if.sink   req_ch,
   oal_rsp_if.source rsp_ch
);
   import oal_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencing: accept, check, walk, drain, put, finish
   oal_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // memory, length, cursor and result register
   oal_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .in_kind         (req_ch.kind),
      .in_value        (req_ch.value),
      .in_position     (req_ch.position),
      .out_status      (rsp_ch.status),
      .out_match_count (rsp_ch.match_count),
      .out_length      (rsp_ch.length)
   );

endmodule

@@ rtl/core/oal_checker.sv @@
// Ordered array list port checker and its bind to the top level.
// Depends on oal_pkg and ordered_array_list.
module oal_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input oal_pkg::status_type       rsp_status,
   input logic [oal_pkg::CNT_W-1:0] rsp_match_count,
   input logic [oal_pkg::LEN_W-1:0] rsp_length
);
   import oal_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_length == LEN_W'(CAPACITY))
      else $error("list full reported below capacity");

   a_match_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_count != '0 |->
         rsp_status == ST_DONE && rsp_match_count <= rsp_length)
      else $error("match count inconsistent with status or length");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_match_count (rsp_ch.match_count),
   .rsp_length      (rsp_ch.length)
);
